// File: src/tzpa_pkg.sv
// ----------------------------------------------------------------------------
// tzpa_pkg
// Shared types and constants for the two-zone pointer acceleration block.
// ----------------------------------------------------------------------------
package tzpa_pkg;

    localparam int TYPE_W   = 8;
    localparam int CODE_W   = 16;
    localparam int VALUE_W  = 32;
    localparam int LIMIT_W  = 16;
    localparam int FACTOR_W = 5;
    localparam int ZONE_W   = 2;
    localparam int MASK_MAX = 16;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;

    // |value * 16 + rest| < 2^36, one guard bit for the sign
    localparam int PROD_W  = 37;
    localparam int REM_W   = 4;
    localparam int QLO_W   = 17;
    localparam int CARRY_W = 5;

    localparam logic [CFG_IDX_W-1:0] REG_EVENT_KIND = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CODE_MASK  = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SLOW_LIMIT = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FAST_LIMIT = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SLOW_MUL   = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SLOW_DIV   = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_FAST_MUL   = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_FAST_DIV   = 4'd7;

    localparam logic [TYPE_W-1:0]   KIND_RESET   = 8'd2;
    localparam logic [MASK_MAX-1:0] MASK_RESET   = 16'd3;
    localparam logic [LIMIT_W-1:0]  SLOW_RESET   = 16'd0;
    localparam logic [LIMIT_W-1:0]  FAST_RESET   = 16'hFFFF;
    localparam logic [FACTOR_W-1:0] FACTOR_RESET = 5'd1;
    localparam logic [FACTOR_W-1:0] FACTOR_MIN   = 5'd1;
    localparam logic [FACTOR_W-1:0] FACTOR_MAX   = 5'd16;

    localparam logic [ZONE_W-1:0] ZONE_NONE   = 2'd0;
    localparam logic [ZONE_W-1:0] ZONE_SLOW   = 2'd1;
    localparam logic [ZONE_W-1:0] ZONE_MIDDLE = 2'd2;
    localparam logic [ZONE_W-1:0] ZONE_FAST   = 2'd3;

    localparam logic [QLO_W-1:0] Q_POS_MAX = 17'd32767;
    localparam logic [QLO_W-1:0] Q_NEG_MAX = 17'd32768;
    localparam logic [QLO_W-1:0] CLAMP_HI  = 17'h07FFF;
    localparam logic [QLO_W-1:0] CLAMP_LO  = 17'h18000;

    typedef struct packed {
        logic [TYPE_W-1:0]   event_kind;
        logic [LIMIT_W-1:0]  slow_limit;
        logic [LIMIT_W-1:0]  fast_limit;
        logic [FACTOR_W-1:0] slow_mul;
        logic [FACTOR_W-1:0] slow_div;
        logic [FACTOR_W-1:0] fast_mul;
        logic [FACTOR_W-1:0] fast_div;
    } cfg_t;

    function automatic logic [FACTOR_W-1:0] sat_factor(input logic [FACTOR_W-1:0] f);
        logic [FACTOR_W-1:0] r;
        if (f < FACTOR_MIN) begin
            r = FACTOR_MIN;
        end else if (f > FACTOR_MAX) begin
            r = FACTOR_MAX;
        end else begin
            r = f;
        end
        return r;
    endfunction

endpackage

// File: src/tzpa_cfg_regs.sv
// ----------------------------------------------------------------------------
// tzpa_cfg_regs
// Configuration register file, written through the index/data channel.
// ----------------------------------------------------------------------------
module tzpa_cfg_regs #(
    parameter int MASK_BITS = 16
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_valid,
    input  logic [tzpa_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tzpa_pkg::CFG_DATA_W-1:0] cfg_data,
    output tzpa_pkg::cfg_t               cfg,
    output logic [MASK_BITS-1:0]         code_mask
);
    import tzpa_pkg::*;

    cfg_t                 cfg_reg;
    logic [MASK_BITS-1:0] mask_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.event_kind <= KIND_RESET;
            cfg_reg.slow_limit <= SLOW_RESET;
            cfg_reg.fast_limit <= FAST_RESET;
            cfg_reg.slow_mul   <= FACTOR_RESET;
            cfg_reg.slow_div   <= FACTOR_RESET;
            cfg_reg.fast_mul   <= FACTOR_RESET;
            cfg_reg.fast_div   <= FACTOR_RESET;
            mask_reg           <= MASK_BITS'(MASK_RESET);
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_EVENT_KIND: cfg_reg.event_kind <= cfg_data[TYPE_W-1:0];
                REG_CODE_MASK:  mask_reg           <= cfg_data[MASK_BITS-1:0];
                REG_SLOW_LIMIT: cfg_reg.slow_limit <= cfg_data[LIMIT_W-1:0];
                REG_FAST_LIMIT: cfg_reg.fast_limit <= cfg_data[LIMIT_W-1:0];
                REG_SLOW_MUL:   cfg_reg.slow_mul   <= cfg_data[FACTOR_W-1:0];
                REG_SLOW_DIV:   cfg_reg.slow_div   <= cfg_data[FACTOR_W-1:0];
                REG_FAST_MUL:   cfg_reg.fast_mul   <= cfg_data[FACTOR_W-1:0];
                REG_FAST_DIV:   cfg_reg.fast_div   <= cfg_data[FACTOR_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg       = cfg_reg;
    assign code_mask = mask_reg;

endmodule

// File: src/tzpa_serial_mul.sv
// ----------------------------------------------------------------------------
// tzpa_serial_mul
// Bit-serial value * factor + rest, LSB first, with an on-the-fly negated
// copy so the magnitude and sign are ready when the last bit is out.
// ----------------------------------------------------------------------------
module tzpa_serial_mul (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               start,
    input  logic signed [tzpa_pkg::VALUE_W-1:0]  value,
    input  logic [tzpa_pkg::FACTOR_W-1:0]      factor,
    input  logic signed [tzpa_pkg::CARRY_W-1:0]  carry_in,
    output logic                               done,
    output logic [tzpa_pkg::PROD_W-1:0]        mag,
    output logic                               neg
);
    import tzpa_pkg::*;

    localparam int ACC_W = 7;
    localparam int CNT_W = $clog2(PROD_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(PROD_W - 1);

    logic                    busy_reg;
    logic                    done_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic [VALUE_W-1:0]      val_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic                    seen_reg;
    logic [PROD_W-1:0]       p_reg;
    logic [PROD_W-1:0]       n_reg;

    logic signed [ACC_W-1:0] sum;
    logic                    pbit;
    logic                    nbit;

    always_comb begin
        sum  = acc_reg + (val_reg[0] ? $signed({2'b00, factor}) : $signed(7'd0));
        pbit = sum[0];
        nbit = pbit ^ seen_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            val_reg  <= value;
            acc_reg  <= ACC_W'(carry_in);
            seen_reg <= 1'b0;
        end else if (busy_reg) begin
            val_reg  <= {val_reg[VALUE_W-1], val_reg[VALUE_W-1:1]};
            acc_reg  <= sum >>> 1;
            seen_reg <= seen_reg | pbit;
            p_reg    <= {pbit, p_reg[PROD_W-1:1]};
            n_reg    <= {nbit, n_reg[PROD_W-1:1]};
        end
    end

    assign done = done_reg;
    assign neg  = p_reg[PROD_W-1];
    assign mag  = neg ? n_reg : p_reg;

endmodule

// File: src/tzpa_serial_div.sv
// ----------------------------------------------------------------------------
// tzpa_serial_div
// Restoring divider, one dividend bit per cycle MSB first, small divisor.
// Keeps the low quotient bits plus a sticky flag for anything above them.
// ----------------------------------------------------------------------------
module tzpa_serial_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [tzpa_pkg::PROD_W-1:0]   dividend,
    input  logic [tzpa_pkg::FACTOR_W-1:0] divisor,
    output logic                          done,
    output logic                          q_hi,
    output logic [tzpa_pkg::QLO_W-1:0]    q_lo,
    output logic [tzpa_pkg::REM_W-1:0]    rem
);
    import tzpa_pkg::*;

    localparam int CNT_W = $clog2(PROD_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(PROD_W - 1);

    logic               busy_reg;
    logic               done_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [PROD_W-1:0]  num_reg;
    logic [REM_W-1:0]   rem_reg;
    logic [QLO_W-1:0]   qlo_reg;
    logic               hi_reg;

    logic [FACTOR_W-1:0] trial;
    logic [FACTOR_W-1:0] diff;
    logic                geq;
    logic [REM_W-1:0]    rem_next;

    always_comb begin
        trial    = {rem_reg, num_reg[PROD_W-1]};
        geq      = (trial >= divisor);
        diff     = trial - divisor;
        rem_next = geq ? diff[REM_W-1:0] : trial[REM_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            num_reg <= dividend;
            rem_reg <= '0;
            qlo_reg <= '0;
            hi_reg  <= 1'b0;
        end else if (busy_reg) begin
            num_reg <= {num_reg[PROD_W-2:0], 1'b0};
            rem_reg <= rem_next;
            qlo_reg <= {qlo_reg[QLO_W-2:0], geq};
            hi_reg  <= hi_reg | qlo_reg[QLO_W-1];
        end
    end

    assign done = done_reg;
    assign q_hi = hi_reg;
    assign q_lo = qlo_reg;
    assign rem  = rem_reg;

endmodule

// File: src/two_zone_pointer_acceleration_top.sv
// ----------------------------------------------------------------------------
// two_zone_pointer_acceleration_top
// Passthrough events go classify, then output load; scaled events go classify,
// serial multiply, serial divide, output load (each serial unit shifts 37 bits).
// Throughput: one event at a time; the next is taken once the previous result
// sits in the output register.
// Reset: synchronous on aresetn low; registers to defaults, remainder zero.
// ----------------------------------------------------------------------------
module two_zone_pointer_acceleration_top #(
    parameter int CODE_SLOTS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // ev_code[15:0], ev_value[47:16]
    input  logic [7:0]  s_tuser,   // ev_type[7:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // out_value[31:0]
    output logic [1:0]  m_tuser,   // zone[1:0]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [tzpa_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tzpa_pkg::CFG_DATA_W-1:0] cfg_data
);
    import tzpa_pkg::*;

    localparam int MASK_BITS = (CODE_SLOTS < MASK_MAX) ? CODE_SLOTS : MASK_MAX;
    localparam int IDX_W     = (MASK_BITS > 1) ? $clog2(MASK_BITS) : 1;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_CLASS = 5'b00010,
        ST_MUL   = 5'b00100,
        ST_DIV   = 5'b01000,
        ST_HOLD  = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    cfg_t                 cfg;
    logic [MASK_BITS-1:0] code_mask;

    logic [TYPE_W-1:0]         type_reg;
    logic [CODE_W-1:0]         code_reg;
    logic signed [VALUE_W-1:0] value_reg;
    logic signed [CARRY_W-1:0] carry_reg, carry_next;
    logic                      fast_reg;
    logic [ZONE_W-1:0]         res_zone_reg, res_zone_next;
    logic [VALUE_W-1:0]        res_value_reg, res_value_next;
    logic                      m_valid_reg;
    logic [VALUE_W-1:0]        m_data_reg;
    logic [ZONE_W-1:0]         m_user_reg;

    logic                      s_accept;
    logic                      code_hit;
    logic                      handled;
    logic [VALUE_W:0]          mag_w;
    logic                      slow_hit;
    logic                      fast_hit;
    logic                      mul_start;
    logic signed [CARRY_W-1:0] mul_carry;
    logic [FACTOR_W-1:0]       mul_factor;
    logic [FACTOR_W-1:0]       div_factor;
    logic                      mul_done;
    logic [PROD_W-1:0]         mul_mag;
    logic                      mul_neg;
    logic                      div_done;
    logic                      q_hi;
    logic [QLO_W-1:0]          q_lo;
    logic [REM_W-1:0]          q_rem;
    logic                      clamp;
    logic [QLO_W-1:0]          q_signed;
    logic [QLO_W-1:0]          res17;
    logic [CARRY_W-1:0]        rest;
    logic                      out_free;

    tzpa_cfg_regs #(
        .MASK_BITS (MASK_BITS)
    ) u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg),
        .code_mask (code_mask)
    );

    tzpa_serial_mul u_mul (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (mul_start),
        .value    (value_reg),
        .factor   (mul_factor),
        .carry_in (mul_carry),
        .done     (mul_done),
        .mag      (mul_mag),
        .neg      (mul_neg)
    );

    tzpa_serial_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (mul_done),
        .dividend (mul_mag),
        .divisor  (div_factor),
        .done     (div_done),
        .q_hi     (q_hi),
        .q_lo     (q_lo),
        .rem      (q_rem)
    );

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign s_accept  = s_tvalid & s_tready;
    assign out_free  = ~m_valid_reg | m_tready;

    assign mul_factor = fast_reg ? sat_factor(cfg.fast_mul) : sat_factor(cfg.slow_mul);
    assign div_factor = fast_reg ? sat_factor(cfg.fast_div) : sat_factor(cfg.slow_div);

    always_comb begin
        code_hit = (code_reg < CODE_W'(MASK_BITS)) && code_mask[code_reg[IDX_W-1:0]];
        handled  = (type_reg == cfg.event_kind) && code_hit;
        mag_w    = value_reg[VALUE_W-1] ? ((VALUE_W+1)'(0) - {1'b1, value_reg})
                                        : {1'b0, value_reg};
        slow_hit = (mag_w <= (VALUE_W+1)'(cfg.slow_limit));
        fast_hit = (mag_w >= (VALUE_W+1)'(cfg.fast_limit));
    end

    always_comb begin
        clamp    = q_hi | (mul_neg ? (q_lo > Q_NEG_MAX) : (q_lo > Q_POS_MAX));
        q_signed = mul_neg ? (QLO_W'(0) - q_lo) : q_lo;
        res17    = clamp ? (mul_neg ? CLAMP_LO : CLAMP_HI) : q_signed;
        rest     = mul_neg ? (CARRY_W'(0) - {1'b0, q_rem}) : {1'b0, q_rem};
    end

    always_comb begin
        state_next     = state_reg;
        carry_next     = carry_reg;
        res_zone_next  = res_zone_reg;
        res_value_next = res_value_reg;
        mul_start      = 1'b0;
        mul_carry      = carry_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    state_next = ST_CLASS;
                end
            end
            ST_CLASS: begin
                res_value_next = value_reg;
                if (!handled) begin
                    res_zone_next = ZONE_NONE;
                    state_next    = ST_HOLD;
                end else if (slow_hit) begin
                    res_zone_next = ZONE_SLOW;
                    mul_start     = 1'b1;
                    state_next    = ST_MUL;
                end else begin
                    carry_next = '0;
                    if (fast_hit) begin
                        res_zone_next = ZONE_FAST;
                        mul_carry     = '0;
                        mul_start     = 1'b1;
                        state_next    = ST_MUL;
                    end else begin
                        res_zone_next = ZONE_MIDDLE;
                        state_next    = ST_HOLD;
                    end
                end
            end
            ST_MUL: begin
                if (mul_done) begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    res_value_next = {{(VALUE_W-QLO_W){res17[QLO_W-1]}}, res17};
                    carry_next     = clamp ? '0 : $signed(rest);
                    state_next     = ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            carry_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            carry_reg <= carry_next;
            if (state_reg == ST_HOLD && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            type_reg  <= s_tuser[TYPE_W-1:0];
            code_reg  <= s_tdata[CODE_W-1:0];
            value_reg <= $signed(s_tdata[CODE_W+VALUE_W-1:CODE_W]);
        end
        if (state_reg == ST_CLASS) begin
            fast_reg <= ~slow_hit;
        end
        res_zone_reg  <= res_zone_next;
        res_value_reg <= res_value_next;
        if (state_reg == ST_HOLD && out_free) begin
            m_data_reg <= res_value_reg;
            m_user_reg <= res_zone_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule

// File: tb/sv/pointer_accel_checker.sv
// ----------------------------------------------------------------------------
// pointer_accel_checker
// Watches the event, result and register channels of the two-zone pointer
// acceleration block. It keeps its own copy of the registers and of the
// carried remainder, predicts one result per accepted event and compares
// each accepted result, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module pointer_accel_checker #(
    parameter int CODE_SLOTS = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    input  logic                              s_tready,
    input  logic [47:0]                       s_tdata,   // ev_code[15:0], ev_value[47:16]
    input  logic [7:0]                        s_tuser,   // ev_type[7:0]
    input  logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic [31:0]                       m_tdata,   // out_value[31:0]
    input  logic [1:0]                        m_tuser,   // zone[1:0]
    input  logic                              cfg_valid,
    input  logic                              cfg_ready,
    input  logic [tzpa_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tzpa_pkg::CFG_DATA_W-1:0]   cfg_data,
    output int                                fail_count,
    output int                                backlog,
    output int                                seen_none,
    output int                                seen_slow,
    output int                                seen_middle,
    output int                                seen_fast
);
    timeunit 1ns;
    timeprecision 1ps;

    import tzpa_pkg::*;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic [ZONE_W-1:0]         zone;
    } motion_t;

    logic [TYPE_W-1:0]     kind_q;
    logic [MASK_MAX-1:0]   mask_q;
    logic [LIMIT_W-1:0]    slow_lim_q;
    logic [LIMIT_W-1:0]    fast_lim_q;
    logic [FACTOR_W-1:0]   slow_mul_q;
    logic [FACTOR_W-1:0]   slow_div_q;
    logic [FACTOR_W-1:0]   fast_mul_q;
    logic [FACTOR_W-1:0]   fast_div_q;
    logic signed [CARRY_W-1:0] carry_q;

    motion_t pending_motion[$];

    function automatic longint clip_factor(input logic [FACTOR_W-1:0] f);
        if (f < FACTOR_MIN) return 1;
        if (f > FACTOR_MAX) return 16;
        return longint'(f);
    endfunction

    function automatic logic signed [VALUE_W-1:0] scale_with_carry(
        input longint v, input logic [FACTOR_W-1:0] mul, input logic [FACTOR_W-1:0] div);
        longint m;
        longint d;
        longint prod;
        longint q;
        longint c;
        m = clip_factor(mul);
        d = clip_factor(div);
        prod = v * m + longint'(carry_q);
        q = prod / d;
        c = q;
        if (c < -32768) c = -32768;
        if (c > 32767) c = 32767;
        carry_q = (c == q) ? CARRY_W'(prod - q * d) : '0;
        return VALUE_W'(c);
    endfunction

    function automatic motion_t predict_motion(input logic [TYPE_W-1:0] ev_type,
                                               input logic [CODE_W-1:0] ev_code,
                                               input logic signed [VALUE_W-1:0] ev_value);
        motion_t r;
        longint v;
        longint mag;
        r.value = ev_value;
        r.zone  = ZONE_NONE;
        v = longint'(ev_value);
        mag = (v < 0) ? -v : v;
        if (ev_type == kind_q && ev_code < CODE_SLOTS && ev_code < MASK_MAX
                && mask_q[ev_code]) begin
            if (mag <= longint'(slow_lim_q)) begin
                r.value = scale_with_carry(v, slow_mul_q, slow_div_q);
                r.zone  = ZONE_SLOW;
            end else begin
                carry_q = '0;
                if (mag >= longint'(fast_lim_q)) begin
                    r.value = scale_with_carry(v, fast_mul_q, fast_div_q);
                    r.zone  = ZONE_FAST;
                end else begin
                    r.zone  = ZONE_MIDDLE;
                end
            end
        end
        return r;
    endfunction

    always @(posedge aclk) begin
        motion_t want;
        if (!aresetn) begin
            kind_q     = KIND_RESET;
            mask_q     = MASK_RESET;
            slow_lim_q = SLOW_RESET;
            fast_lim_q = FAST_RESET;
            slow_mul_q = FACTOR_RESET;
            slow_div_q = FACTOR_RESET;
            fast_mul_q = FACTOR_RESET;
            fast_div_q = FACTOR_RESET;
            carry_q    = '0;
            pending_motion.delete();
            fail_count  = 0;
            seen_none   = 0;
            seen_slow   = 0;
            seen_middle = 0;
            seen_fast   = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_EVENT_KIND: kind_q     = cfg_data[TYPE_W-1:0];
                    REG_CODE_MASK:  mask_q     = cfg_data[MASK_MAX-1:0];
                    REG_SLOW_LIMIT: slow_lim_q = cfg_data[LIMIT_W-1:0];
                    REG_FAST_LIMIT: fast_lim_q = cfg_data[LIMIT_W-1:0];
                    REG_SLOW_MUL:   slow_mul_q = cfg_data[FACTOR_W-1:0];
                    REG_SLOW_DIV:   slow_div_q = cfg_data[FACTOR_W-1:0];
                    REG_FAST_MUL:   fast_mul_q = cfg_data[FACTOR_W-1:0];
                    REG_FAST_DIV:   fast_div_q = cfg_data[FACTOR_W-1:0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                if (pending_motion.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("[%0t] unexpected result: value=%0d zone=%0d",
                                 $time, $signed(m_tdata), m_tuser);
                end else begin
                    want = pending_motion.pop_front();
                    case (want.zone)
                        ZONE_NONE:   seen_none++;
                        ZONE_SLOW:   seen_slow++;
                        ZONE_MIDDLE: seen_middle++;
                        default:     seen_fast++;
                    endcase
                    if (m_tdata !== want.value || m_tuser !== want.zone) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("[%0t] mismatch: value exp=%0d got=%0d, zone exp=%0d got=%0d",
                                     $time, want.value, $signed(m_tdata), want.zone, m_tuser);
                    end
                end
            end
            if (s_tvalid && s_tready)
                pending_motion.push_back(predict_motion(s_tuser, s_tdata[15:0], s_tdata[47:16]));
        end
        backlog = pending_motion.size();
    end

endmodule

// File: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the two-zone pointer acceleration block. Drives a
// short directed set of events, then random events over several register
// settings and flow-control phases, including one long output hold-off.
// Checking is done by pointer_accel_checker.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tzpa_pkg::*;

    localparam int PHASES       = 8;
    localparam int PHASE_EVENTS = 125;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 120;
    localparam int QUIET_LIMIT  = 4000;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;    // ev_code[15:0], ev_value[47:16]
    logic [7:0]  s_tuser;    // ev_type[7:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;    // out_value[31:0]
    logic [1:0]  m_tuser;    // zone[1:0]
    logic        cfg_valid;
    logic        cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int fail_count;
    int backlog;
    int seen_none;
    int seen_slow;
    int seen_middle;
    int seen_fast;

    int send_idle_pct;
    int recv_stall_pct;
    bit hold_request;
    bit hold_taken;
    int hold_left;
    int quiet_cycles;
    int backpressure_cycles;
    int setups;
    int events_sent;

    logic [TYPE_W-1:0]   cur_kind;
    logic [MASK_MAX-1:0] cur_mask;
    logic [LIMIT_W-1:0]  cur_slow;
    logic [LIMIT_W-1:0]  cur_fast;

    two_zone_pointer_acceleration_top DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    pointer_accel_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .fail_count  (fail_count),
        .backlog     (backlog),
        .seen_none   (seen_none),
        .seen_slow   (seen_slow),
        .seen_middle (seen_middle),
        .seen_fast   (seen_fast)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // result side: random stalls plus one long hold-off on request
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left--;
        end else if (hold_request && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left  = HOLD_CYCLES;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    initial begin
        quiet_cycles = 0;
        backpressure_cycles = 0;
        while (quiet_cycles < QUIET_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                    || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (aresetn && s_tvalid && !s_tready)
                backpressure_cycles++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    task automatic send_event(input logic [TYPE_W-1:0] ev_type,
                              input logic [CODE_W-1:0] ev_code,
                              input logic [VALUE_W-1:0] ev_value);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tuser  <= ev_type;
        s_tdata  <= {ev_value, ev_code};
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        events_sent++;
    endtask

    task automatic drain;
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (backlog != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    task automatic apply_setup(input logic [TYPE_W-1:0] kind, input logic [MASK_MAX-1:0] mask,
                               input logic [LIMIT_W-1:0] slow, input logic [LIMIT_W-1:0] fast,
                               input logic [FACTOR_W-1:0] smul, input logic [FACTOR_W-1:0] sdiv,
                               input logic [FACTOR_W-1:0] fmul, input logic [FACTOR_W-1:0] fdiv);
        drain();
        write_reg(REG_EVENT_KIND, CFG_DATA_W'(kind));
        write_reg(REG_CODE_MASK,  CFG_DATA_W'(mask));
        write_reg(REG_SLOW_LIMIT, CFG_DATA_W'(slow));
        write_reg(REG_FAST_LIMIT, CFG_DATA_W'(fast));
        write_reg(REG_SLOW_MUL,   CFG_DATA_W'(smul));
        write_reg(REG_SLOW_DIV,   CFG_DATA_W'(sdiv));
        write_reg(REG_FAST_MUL,   CFG_DATA_W'(fmul));
        write_reg(REG_FAST_DIV,   CFG_DATA_W'(fdiv));
        cfg_valid <= 1'b0;
        cur_kind = kind;
        cur_mask = mask;
        cur_slow = slow;
        cur_fast = fast;
        setups++;
    endtask

    function automatic logic [FACTOR_W-1:0] pick_factor;
        if ($urandom_range(0, 3) == 0)
            return FACTOR_W'($urandom_range(0, 31));
        return FACTOR_W'($urandom_range(1, 16));
    endfunction

    function automatic logic [VALUE_W-1:0] pick_value;
        longint base;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: base = longint'($urandom_range(0, int'(cur_slow) + 2));
            4, 5:       base = longint'(cur_fast) + longint'(int'($urandom_range(0, 4)) - 2);
            6:          base = longint'($urandom_range(int'(cur_slow), int'(cur_fast)));
            7:          return $urandom;
            8: begin
                case ($urandom_range(0, 3))
                    0:       return 32'h8000_0000;
                    1:       return 32'h7FFF_FFFF;
                    2:       return 32'h0000_0000;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
            default:    base = longint'($urandom_range(0, 5000));
        endcase
        if ($urandom_range(0, 1) == 1) base = -base;
        return base[VALUE_W-1:0];
    endfunction

    task automatic send_random_event;
        int sel;
        logic [CODE_W-1:0] code;
        sel = $urandom_range(0, 99);
        if (sel < 80) begin
            do code = CODE_W'($urandom_range(0, 15)); while (!cur_mask[code[3:0]]);
            send_event(cur_kind, code, pick_value());
        end else if (sel < 90) begin
            send_event(TYPE_W'($urandom), CODE_W'($urandom), $urandom);
        end else if (sel < 95) begin
            send_event(cur_kind, CODE_W'($urandom_range(16, 65535)), pick_value());
        end else begin
            send_event(cur_kind, CODE_W'($urandom_range(0, 15)), pick_value());
        end
    endtask

    initial begin
        logic [LIMIT_W-1:0] slow;
        logic [LIMIT_W-1:0] fast;
        logic [MASK_MAX-1:0] mask;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_request = 1'b0;
        hold_taken   = 1'b0;
        hold_left    = 0;
        setups       = 0;
        events_sent  = 0;
        cur_kind = KIND_RESET;
        cur_mask = MASK_RESET;
        cur_slow = SLOW_RESET;
        cur_fast = FAST_RESET;
        aresetn  = 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // defaults: zero magnitude is slow, large is fast, code 2 disabled
        send_event(8'd2, 16'd0, 32'd0);
        send_event(8'd2, 16'd1, -300);
        send_event(8'd2, 16'd0, 32'h8000_0000);
        send_event(8'd2, 16'd2, 1);

        apply_setup(8'd7, 16'h8005, 16'd10, 16'd100, 5'd3, 5'd4, 5'd5, 5'd2);
        send_event(8'd7, 16'd0, 1);
        send_event(8'd7, 16'd0, 1);
        send_event(8'd7, 16'd2, 1);
        send_event(8'd7, 16'd15, -1);
        send_event(8'd7, 16'd0, -5);
        send_event(8'd7, 16'd0, 10);
        send_event(8'd7, 16'd0, 11);
        send_event(8'd7, 16'd2, -99);
        send_event(8'd7, 16'd0, 3);
        send_event(8'd7, 16'd15, 100);
        send_event(8'd7, 16'd0, -100);
        send_event(8'd7, 16'd0, 32'h7FFF_FFFF);
        send_event(8'd7, 16'd0, 32'h8000_0000);
        send_event(8'd8, 16'd0, 5);
        send_event(8'd7, 16'd1, 5);
        send_event(8'd7, 16'd16, 5);
        send_event(8'd7, 16'hFFFF, -7);

        // overlapping limits, out-of-range factors
        apply_setup(8'd255, 16'hFFFF, 16'hFFFF, 16'd0, 5'd17, 5'd0, 5'd0, 5'd31);
        send_event(8'd255, 16'd15, 65535);
        send_event(8'd255, 16'd0, -65535);
        send_event(8'd255, 16'd3, 7);
        send_event(8'd255, 16'd3, 70001);
        send_event(8'd255, 16'd1, 32'h8000_0000);

        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: apply_setup(8'd2, 16'hFFFF, 16'd40, 16'd400, 5'd3, 5'd7, 5'd16, 5'd16);
                1: apply_setup(8'd0, 16'h0001, 16'd0, 16'd0, 5'd0, 5'd0, 5'd0, 5'd0);
                2: apply_setup(8'd255, 16'h8000, 16'hFFFF, 16'hFFFF, 5'd31, 5'd31, 5'd31, 5'd31);
                default: begin
                    mask = MASK_MAX'($urandom);
                    if (mask == '0) mask[$urandom_range(0, 15)] = 1'b1;
                    slow = ($urandom_range(0, 7) == 0) ? LIMIT_W'($urandom)
                                                       : LIMIT_W'($urandom_range(0, 300));
                    if ($urandom_range(0, 3) == 0)
                        fast = LIMIT_W'($urandom_range(0, int'(slow)));
                    else if (int'(slow) + 600 > 65535)
                        fast = 16'hFFFF;
                    else
                        fast = LIMIT_W'(int'(slow) + int'($urandom_range(0, 600)));
                    apply_setup(TYPE_W'($urandom), mask, slow, fast,
                                pick_factor(), pick_factor(), pick_factor(), pick_factor());
                end
            endcase
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 57; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 57; end
                default: begin send_idle_pct = 6; recv_stall_pct = 6; end
            endcase
            if (ph == 0) hold_request = 1'b1;
            for (int n = 0; n < PHASE_EVENTS; n++)
                send_random_event();
        end

        drain();
        $display("Covered %0d events over %0d register settings: %0d unhandled, %0d slow, %0d middle, %0d fast.",
                 events_sent, setups + 1, seen_none, seen_slow, seen_middle, seen_fast);
        $display("Input held back by the block for %0d cycles, %0d mismatches.",
                 backpressure_cycles, fail_count);
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
